>>> design/pmfl_pkg.sv
// shared types and constants for the position map floor lookup block
// no dependencies; imported by pmfl_store and position_map_floor_lookup
package pmfl_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W = 32;
  localparam int LINE_W = 24;
  localparam int COL_W  = 16;
  localparam int FILE_W = 8;
  localparam int POS_W  = LINE_W + COL_W + FILE_W;

  typedef enum logic [1:0] {
    CMD_ASSOC  = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_ORDER     = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_FETCH,
    ST_DATA
  } state_t;

  typedef struct packed {
    logic             key_we;
    logic             pos_we;
    logic [AW-1:0]    waddr;
    logic [KEY_W-1:0] wkey;
    logic [POS_W-1:0] wpos;
    logic [AW-1:0]    raddr;
  } mem_req_t;

endpackage

>>> design/pmfl_store.sv
// key and source position memories, one write and one registered read port each
// depends on pmfl_pkg
module pmfl_store (
  input  logic                      clk,
  input  pmfl_pkg::mem_req_t        req,
  output logic [pmfl_pkg::KEY_W-1:0] key_rdata,
  output logic [pmfl_pkg::POS_W-1:0] pos_rdata
);
  import pmfl_pkg::*;

  logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
  logic [POS_W-1:0] pos_mem [TABLE_DEPTH];
  logic [KEY_W-1:0] key_rdata_r;
  logic [POS_W-1:0] pos_rdata_r;

  always_ff @(posedge clk) begin
    if (req.key_we) begin
      key_mem[req.waddr] <= req.wkey;
    end
    key_rdata_r <= key_mem[req.raddr];
  end

  always_ff @(posedge clk) begin
    if (req.pos_we) begin
      pos_mem[req.waddr] <= req.wpos;
    end
    pos_rdata_r <= pos_mem[req.raddr];
  end

  assign key_rdata = key_rdata_r;
  assign pos_rdata = pos_rdata_r;

endmodule

>>> design/position_map_floor_lookup.sv
// sorted position table with append, clear and binary search floor lookup
// associate, clear, nop and not-found lookup answer in the cycle after accept, busy stays low
// lookup hit: each probe of the single key memory read port with registered data takes a PROBE
// and a CMP state, then FETCH and DATA read the position; one lookup in flight at a time
// results are strobed for one cycle on out_valid and cannot be stalled
// reset clears the entry count and the sequencer; memory contents are left as they are
module position_map_floor_lookup (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_cmd,
  input  logic [pmfl_pkg::KEY_W-1:0]  in_out_key,
  input  logic [pmfl_pkg::LINE_W-1:0] in_src_line,
  input  logic [pmfl_pkg::COL_W-1:0]  in_src_col,
  input  logic [pmfl_pkg::FILE_W-1:0] in_src_file,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic [pmfl_pkg::LINE_W-1:0] out_hit_line,
  output logic [pmfl_pkg::COL_W-1:0]  out_hit_col,
  output logic [pmfl_pkg::FILE_W-1:0] out_hit_file
);
  import pmfl_pkg::*;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     lo_r, lo_nxt;
  logic [CW-1:0]     hi_r, hi_nxt;
  logic [KEY_W-1:0]  qkey_r, qkey_nxt;
  logic [KEY_W-1:0]  last_key_r, last_key_nxt;
  logic [KEY_W-1:0]  first_key_r, first_key_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [POS_W-1:0]  out_pos_r, out_pos_nxt;

  mem_req_t          req;
  logic [KEY_W-1:0]  key_rdata;
  logic [POS_W-1:0]  pos_rdata;

  logic              accept;
  cmd_t              cmd;
  logic              has_entries;
  logic              is_full;
  logic              miss;
  logic [CW-1:0]     mid;
  logic              go_left;
  logic [CW-1:0]     lo_cmp;
  logic [CW-1:0]     hi_cmp;
  logic              more_probes;

  pmfl_store u_store (
    .clk       (clk),
    .req       (req),
    .key_rdata (key_rdata),
    .pos_rdata (pos_rdata)
  );

  assign busy        = (state_r != ST_IDLE);
  assign accept      = start && !busy;
  assign cmd         = cmd_t'(in_cmd);
  assign has_entries = (count_r != '0);
  assign is_full     = (count_r == CW'(TABLE_DEPTH));
  assign miss        = !has_entries || (in_out_key < first_key_r);
  assign mid         = lo_r + ((hi_r - lo_r) >> 1);
  assign go_left     = (qkey_r < key_rdata);
  assign lo_cmp      = go_left ? lo_r : mid;
  assign hi_cmp      = go_left ? mid : hi_r;
  assign more_probes = ((hi_cmp - lo_cmp) > CW'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && cmd == CMD_LOOKUP && !miss) begin
          state_nxt = (count_r == CW'(1)) ? ST_FETCH : ST_PROBE;
        end
      end
      ST_PROBE: state_nxt = ST_CMP;
      ST_CMP:   state_nxt = more_probes ? ST_PROBE : ST_FETCH;
      ST_FETCH: state_nxt = ST_DATA;
      ST_DATA:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_nxt      = count_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    qkey_nxt       = qkey_r;
    last_key_nxt   = last_key_r;
    first_key_nxt  = first_key_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    req.key_we     = 1'b0;
    req.pos_we     = 1'b0;
    req.waddr      = count_r[AW-1:0];
    req.wkey       = in_out_key;
    req.wpos       = {in_src_line, in_src_col, in_src_file};
    req.raddr      = mid[AW-1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_pos_nxt = '0;
          unique case (cmd)
            CMD_ASSOC: begin
              out_valid_nxt = 1'b1;
              priority if (has_entries && last_key_r > in_out_key) begin
                out_status_nxt = STAT_ORDER;
              end else if (has_entries && last_key_r == in_out_key) begin
                out_status_nxt = STAT_OK;
                req.pos_we     = 1'b1;
                req.waddr      = AW'(count_r - CW'(1));
              end else if (is_full) begin
                out_status_nxt = STAT_FULL;
              end else begin
                out_status_nxt = STAT_OK;
                req.key_we     = 1'b1;
                req.pos_we     = 1'b1;
                count_nxt      = count_r + CW'(1);
                last_key_nxt   = in_out_key;
                if (!has_entries) begin
                  first_key_nxt = in_out_key;
                end
              end
            end
            CMD_LOOKUP: begin
              if (miss) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_NOT_FOUND;
              end else begin
                lo_nxt   = '0;
                hi_nxt   = count_r;
                qkey_nxt = in_out_key;
              end
            end
            CMD_CLEAR: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_OK;
              count_nxt      = '0;
            end
            CMD_NOP: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_OK;
            end
            default: ;
          endcase
        end
      end
      ST_PROBE: req.raddr = mid[AW-1:0];
      ST_CMP: begin
        lo_nxt = lo_cmp;
        hi_nxt = hi_cmp;
      end
      ST_FETCH: req.raddr = lo_r[AW-1:0];
      ST_DATA: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = STAT_OK;
        out_pos_nxt    = pos_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    qkey_r       <= qkey_nxt;
    last_key_r   <= last_key_nxt;
    first_key_r  <= first_key_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_hit_line = out_pos_r[POS_W-1 -: LINE_W];
  assign out_hit_col  = out_pos_r[FILE_W +: COL_W];
  assign out_hit_file = out_pos_r[FILE_W-1:0];

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_probe_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROBE || state_r == ST_CMP) |-> ((hi_r - lo_r) > CW'(1)) && (hi_r <= count_r))
    else $error("probe window collapsed or past entry count");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_OK) |-> (out_pos_r == '0))
    else $error("hit fields set on a failed item");

  a_empty_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && cmd == CMD_LOOKUP && count_r == '0) |=> (out_valid && out_status == STAT_NOT_FOUND))
    else $error("lookup on empty table did not report not found");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DATA) |=> (out_valid && state_r == ST_IDLE))
    else $error("lookup hit not delivered");

endmodule

>>> dv/position_map_floor_lookup_tb.sv
// testbench for position_map_floor_lookup: directed items, a full-table phase and random items
// a scoreboard class predicts each result from its own copy of the position table
// depends on pmfl_pkg and the position_map_floor_lookup rtl
module position_map_floor_lookup_tb;
  import pmfl_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    status_t           status;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
    logic [FILE_W-1:0] file;
  } floor_answer_t;

  class floor_map_scoreboard;
    logic [KEY_W-1:0] key_tab [TABLE_DEPTH];
    logic [POS_W-1:0] pos_tab [TABLE_DEPTH];
    int unsigned      used;
    floor_answer_t    pending[$];
    int               errors;

    function new();
      used   = 0;
      errors = 0;
    endfunction

    function void note_item(cmd_t cmd, logic [KEY_W-1:0] key, logic [LINE_W-1:0] line,
                            logic [COL_W-1:0] col, logic [FILE_W-1:0] file);
      floor_answer_t a;
      int            pick;
      int            i;
      a = '0;
      a.status = STAT_OK;
      case (cmd)
        CMD_ASSOC: begin
          if (used > 0 && key_tab[used-1] > key) begin
            a.status = STAT_ORDER;
          end else if (used > 0 && key_tab[used-1] == key) begin
            pos_tab[used-1] = {line, col, file};
          end else if (used >= TABLE_DEPTH) begin
            a.status = STAT_FULL;
          end else begin
            key_tab[used] = key;
            pos_tab[used] = {line, col, file};
            used++;
          end
        end
        CMD_LOOKUP: begin
          pick = -1;
          for (i = 0; i < used; i++) begin
            if (key_tab[i] <= key) pick = i;
          end
          if (pick < 0) begin
            a.status = STAT_NOT_FOUND;
          end else begin
            {a.line, a.col, a.file} = pos_tab[pick];
          end
        end
        CMD_CLEAR: used = 0;
        default: ;
      endcase
      pending.push_back(a);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("[%0t] mismatch, %s: got %0h, expected %0h", $time, what, got, want);
      errors++;
    endtask

    task check_result(status_t st, logic [LINE_W-1:0] line, logic [COL_W-1:0] col,
                      logic [FILE_W-1:0] file);
      floor_answer_t e;
      if (pending.size() == 0) begin
        report("result with no item pending, status", st, 0);
        return;
      end
      e = pending.pop_front();
      if (st != e.status) report("status", st, e.status);
      if (line != e.line) report("hit_line", line, e.line);
      if (col != e.col) report("hit_col", col, e.col);
      if (file != e.file) report("hit_file", file, e.file);
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        in_cmd = CMD_NOP;
  logic [KEY_W-1:0]  in_out_key = '0;
  logic [LINE_W-1:0] in_src_line = '0;
  logic [COL_W-1:0]  in_src_col = '0;
  logic [FILE_W-1:0] in_src_file = '0;
  logic              out_valid;
  logic [1:0]        out_status;
  logic [LINE_W-1:0] out_hit_line;
  logic [COL_W-1:0]  out_hit_col;
  logic [FILE_W-1:0] out_hit_file;

  floor_map_scoreboard sb = new();
  bit                  idle_on = 1'b1;
  int                  quiet = 0;

  position_map_floor_lookup dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_cmd       (in_cmd),
    .in_out_key   (in_out_key),
    .in_src_line  (in_src_line),
    .in_src_col   (in_src_col),
    .in_src_file  (in_src_file),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_hit_line (out_hit_line),
    .out_hit_col  (out_hit_col),
    .out_hit_file (out_hit_file)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_result(status_t'(out_status), out_hit_line, out_hit_col, out_hit_file);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("** position_map_floor_lookup: FAILED **");
      $finish;
    end
  end

  // called at a rising edge; returns at the edge that accepts the item
  task send_item(cmd_t c, logic [KEY_W-1:0] k, logic [LINE_W-1:0] line,
                 logic [COL_W-1:0] col, logic [FILE_W-1:0] file);
    start       <= 1'b1;
    in_cmd      <= c;
    in_out_key  <= k;
    in_src_line <= line;
    in_src_col  <= col;
    in_src_file <= file;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(c, k, line, col, file);
  endtask

  task send_rand(cmd_t c, logic [KEY_W-1:0] k);
    send_item(c, k, LINE_W'($urandom()), COL_W'($urandom()), FILE_W'($urandom()));
  endtask

  task pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task idle_maybe();
    if (idle_on && $urandom_range(99) < 9) pause($urandom_range(1, 6));
  endtask

  task drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] next_assoc_key();
    int unsigned      r;
    logic [KEY_W-1:0] last;
    logic [KEY_W:0]   sum;
    r = $urandom_range(99);
    if (sb.used == 0) return (r < 50) ? KEY_W'($urandom_range(0, 1000)) : KEY_W'($urandom());
    last = sb.key_tab[sb.used-1];
    if (r < 10) return last;
    if (r < 18 && last != '0) return KEY_W'($urandom_range(0, last - 1));
    if (r < 22) return KEY_W'($urandom());
    sum = {1'b0, last} + (KEY_W+1)'($urandom_range(1, (r < 80) ? 16 : (1 << 20)));
    return sum[KEY_W] ? '1 : sum[KEY_W-1:0];
  endfunction

  function automatic logic [KEY_W-1:0] pick_query();
    int unsigned      r;
    logic [KEY_W-1:0] k;
    if (sb.used == 0) return KEY_W'($urandom());
    r = $urandom_range(99);
    k = sb.key_tab[$urandom_range(0, sb.used - 1)];
    if (r < 35) return k;
    if (r < 55) return k + 1'b1;
    if (r < 70) return k - 1'b1;
    if (r < 78) return sb.key_tab[0] - 1'b1;
    if (r < 85) return '1;
    return KEY_W'($urandom());
  endfunction

  initial begin
    logic [KEY_W-1:0] last;
    int unsigned      r;
    int               n;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, overwrite, order errors, key extremes, clear
    send_item(CMD_LOOKUP, '0, '0, '0, '0);
    send_item(CMD_LOOKUP, '1, '1, '1, '1);
    send_item(CMD_CLEAR, '0, '0, '0, '0);
    send_item(CMD_NOP, '1, '1, '1, '1);
    send_item(CMD_ASSOC, '0, '0, '0, '0);
    send_item(CMD_ASSOC, '0, '1, '1, '1);
    send_item(CMD_LOOKUP, '0, '0, '0, '0);
    send_item(CMD_LOOKUP, '1, '0, '0, '0);
    send_item(CMD_ASSOC, 32'h8000_0000, 24'h5a5a5a, 16'ha5a5, 8'h5a);
    send_item(CMD_ASSOC, 32'h7fff_ffff, '1, '1, '1);
    send_item(CMD_LOOKUP, 32'h7fff_ffff, '0, '0, '0);
    send_item(CMD_LOOKUP, 32'h8000_0000, '0, '0, '0);
    send_item(CMD_ASSOC, '1, '1, '1, '1);
    send_item(CMD_ASSOC, '1, 24'ha5a5a5, 16'h5a5a, 8'ha5);
    send_item(CMD_LOOKUP, '1, '0, '0, '0);
    send_item(CMD_ASSOC, '0, '1, '1, '1);
    send_item(CMD_NOP, '0, '0, '0, '0);
    send_item(CMD_CLEAR, '1, '1, '1, '1);
    send_item(CMD_LOOKUP, '1, '0, '0, '0);
    send_rand(CMD_ASSOC, 32'd100);
    send_item(CMD_LOOKUP, 32'd99, '0, '0, '0);
    send_item(CMD_LOOKUP, 32'd100, '0, '0, '0);
    send_item(CMD_LOOKUP, 32'd101, '0, '0, '0);
    send_item(CMD_CLEAR, '0, '0, '0, '0);
    drain();

    // fill the table to its depth, then hit the full-table cases
    while (sb.used < TABLE_DEPTH) begin
      if (sb.used > 0 && $urandom_range(99) < 10) begin
        send_rand(CMD_LOOKUP, pick_query());
      end else if (sb.used == 0) begin
        send_rand(CMD_ASSOC, KEY_W'($urandom_range(0, 255)));
      end else begin
        send_rand(CMD_ASSOC, sb.key_tab[sb.used-1] + KEY_W'($urandom_range(1, 1 << 20)));
      end
      idle_maybe();
    end
    last = sb.key_tab[TABLE_DEPTH-1];
    send_rand(CMD_ASSOC, last + 1'b1);
    send_rand(CMD_ASSOC, last);
    send_rand(CMD_ASSOC, '1);
    send_rand(CMD_ASSOC, '0);
    send_rand(CMD_LOOKUP, '1);
    send_rand(CMD_LOOKUP, sb.key_tab[0]);
    send_rand(CMD_LOOKUP, sb.key_tab[0] - 1'b1);
    send_rand(CMD_LOOKUP, last);
    for (n = 0; n < 40; n++) begin
      send_rand(CMD_LOOKUP, pick_query());
      idle_maybe();
    end
    drain();
    send_rand(CMD_CLEAR, KEY_W'($urandom()));

    for (n = 0; n < 350; n++) begin
      idle_on = !(n >= 100 && n < 250);
      r = $urandom_range(99);
      if (r < 2) begin
        send_rand(CMD_CLEAR, KEY_W'($urandom()));
      end else if (r < 4) begin
        send_rand(CMD_NOP, KEY_W'($urandom()));
      end else if (r < 52) begin
        send_rand(CMD_ASSOC, next_assoc_key());
      end else begin
        send_rand(CMD_LOOKUP, pick_query());
      end
      idle_maybe();
    end

    drain();
    repeat (40) @(posedge clk);
    if (sb.pending.size() != 0) sb.report("results never arrived, count", 0, sb.pending.size());
    if (sb.errors == 0) begin
      $display("** position_map_floor_lookup: PASSED **");
    end else begin
      $display("** position_map_floor_lookup: FAILED **");
    end
    $finish;
  end

endmodule
